### rtl/tlag_pkg.sv
package tlag_pkg;

  // Operation codes carried in the input tuser
  typedef enum logic [2:0] {
    FUNC_WRITE = 3'd0,
    FUNC_READ  = 3'd1,
    FUNC_CLEAR = 3'd2,
    FUNC_START = 3'd3,
    FUNC_TICK  = 3'd4
  } func_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_GEN,
    ST_DRAIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic read_done;
    logic clear_run;
    logic gen_issue;
    logic gen_finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_t func;
    logic  gen_due;
    logic  clear_last;
    logic  issue_last;
    logic  skid_full;
  } dp_status_t;

  localparam logic [7:0] FRAME_MAX     = 8'd255;
  localparam logic [7:0] FPG_RESET     = 8'd1;
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

### rtl/tlag_ram.sv
module tlag_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/tlag_ctrl.sv
module tlag_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  tlag_pkg::dp_status_t   status,
  output tlag_pkg::ctrl_cmd_t    cmd
);

  tlag_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlag_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    cmd.accept     = 1'b0;
    cmd.read_done  = 1'b0;
    cmd.clear_run  = 1'b0;
    cmd.gen_issue  = 1'b0;
    cmd.gen_finish = 1'b0;
    case (state_r)
      tlag_pkg::ST_IDLE: begin
        in_tready  = !status.skid_full;
        cmd.accept = in_tvalid && !status.skid_full;
        if (cmd.accept) begin
          case (status.func)
            tlag_pkg::FUNC_READ:  state_nxt = tlag_pkg::ST_READ;
            tlag_pkg::FUNC_CLEAR: state_nxt = tlag_pkg::ST_CLEAR;
            tlag_pkg::FUNC_TICK: begin
              if (status.gen_due) begin
                state_nxt = tlag_pkg::ST_GEN;
              end
            end
            default: state_nxt = tlag_pkg::ST_IDLE;
          endcase
        end
      end
      tlag_pkg::ST_READ: begin
        cmd.read_done = 1'b1;
        state_nxt     = tlag_pkg::ST_IDLE;
      end
      tlag_pkg::ST_CLEAR: begin
        cmd.clear_run = 1'b1;
        if (status.clear_last) begin
          state_nxt = tlag_pkg::ST_IDLE;
        end
      end
      tlag_pkg::ST_GEN: begin
        cmd.gen_issue = 1'b1;
        if (status.issue_last) begin
          state_nxt = tlag_pkg::ST_DRAIN;
        end
      end
      tlag_pkg::ST_DRAIN: begin
        cmd.gen_finish = 1'b1;
        state_nxt      = tlag_pkg::ST_IDLE;
      end
      default: state_nxt = tlag_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/tlag_dp.sv
module tlag_dp #(
  parameter int GRID_COLS = 128,
  parameter int GRID_ROWS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           in_func,
  input  logic [6:0]           in_col,
  input  logic [5:0]           in_row,
  input  logic                 in_cell_value,
  input  logic                 cfg_valid,
  input  logic [7:0]           cfg_data,
  input  tlag_pkg::ctrl_cmd_t  cmd,
  output tlag_pkg::dp_status_t status,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic                 out_cell_alive,
  output logic                 out_is_playing,
  output logic                 out_advanced
);

  localparam int DEPTH  = GRID_COLS * GRID_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(GRID_COLS);
  localparam int RW     = $clog2(GRID_ROWS);
  localparam int PHASES = GRID_ROWS + 3;
  localparam int PW     = $clog2(PHASES);

  typedef struct packed {
    logic advanced;
    logic is_playing;
    logic cell_alive;
  } result_t;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(AW'(r) * GRID_COLS + AW'(c));
  endfunction

  function automatic logic [GRID_COLS-1:0] rot(input logic [GRID_COLS-1:0] v);
    return {v[0], v[GRID_COLS-1:1]};
  endfunction

  tlag_pkg::func_t func;
  logic            on_grid;
  logic [AW-1:0]   in_addr;

  logic            playing_r, playing_nxt;
  logic [7:0]      fc_r, fc_nxt, fc_inc;
  logic [7:0]      fpg_r;
  logic            frame_hit;
  logic            gen_due;
  logic            buf_sel_r;
  logic            rd_inside_r;

  logic [AW-1:0]   clr_cnt_r;
  logic            clear_last;

  logic [PW-1:0]   rd_phase_r;
  logic [CW-1:0]   rd_col_r;
  logic            col_last, phase_last;
  logic [PW-1:0]   load_row;
  logic [CW-1:0]   load_col;
  logic [AW-1:0]   gen_raddr;

  logic            d_valid_r;
  logic [PW-1:0]   d_phase_r;
  logic [CW-1:0]   d_col_r;
  logic [GRID_COLS-1:0] row_a_r, row_b_r, row_c_r, row_d_r, d_shift;
  logic [3:0]      ncount;
  logic            next_alive;
  logic            gen_we;
  logic [AW-1:0]   gen_waddr;
  logic [PW-1:0]   wr_row;

  logic            cur_we;
  logic [AW-1:0]   cur_waddr;
  logic            cur_wdata;
  logic [AW-1:0]   raddr;
  logic            rdata_a, rdata_b, cur_rdata;

  logic            push;
  result_t         push_res;
  logic            head_v_r, skid_v_r, pop;
  result_t         head_r, skid_r;

  // Decode the input word
  assign func    = tlag_pkg::func_t'(in_func);
  assign on_grid = (in_col < GRID_COLS) && (in_row < GRID_ROWS);
  assign in_addr = on_grid ? cell_addr(RW'(in_row), CW'(in_col)) : '0;

  // Frame counter, saturating
  assign fc_inc    = (fc_r != tlag_pkg::FRAME_MAX) ? fc_r + 8'd1 : fc_r;
  assign frame_hit = fc_inc >= fpg_r;
  assign gen_due   = frame_hit && playing_r;

  // Clearing sweep over the current buffer
  assign clear_last = clr_cnt_r == AW'(DEPTH - 1);

  // Generation read side: phase p loads grid row p-1, wrapped
  assign col_last   = rd_col_r == CW'(GRID_COLS - 1);
  assign phase_last = rd_phase_r == PW'(PHASES - 1);

  always_comb begin
    if (rd_phase_r == '0) begin
      load_row = PW'(GRID_ROWS - 1);
    end else if (rd_phase_r > PW'(GRID_ROWS)) begin
      load_row = rd_phase_r - PW'(GRID_ROWS + 1);
    end else begin
      load_row = rd_phase_r - PW'(1);
    end
  end

  assign load_col  = (rd_col_r == '0) ? CW'(GRID_COLS - 1) : rd_col_r - CW'(1);
  assign gen_raddr = cell_addr(load_row[RW-1:0], load_col);
  assign raddr     = cmd.gen_issue ? gen_raddr : in_addr;

  // Window taps: west at bit 0, centre at bit 1, east at bit 2
  assign cur_rdata = buf_sel_r ? rdata_b : rdata_a;
  assign d_shift   = {cur_rdata, row_d_r[GRID_COLS-1:1]};
  assign ncount    = 4'(row_a_r[0]) + 4'(row_a_r[1]) + 4'(row_a_r[2])
                   + 4'(row_b_r[0]) + 4'(row_b_r[2])
                   + 4'(row_c_r[0]) + 4'(row_c_r[1]) + 4'(row_c_r[2]);
  assign next_alive = (ncount == tlag_pkg::BIRTH_COUNT)
                   || (row_b_r[1] && ncount == tlag_pkg::SURVIVE_COUNT);
  assign wr_row    = d_phase_r - PW'(3);
  assign gen_we    = d_valid_r && (d_phase_r >= PW'(3));
  assign gen_waddr = cell_addr(wr_row[RW-1:0], d_col_r);

  // Apply the accepted word and build its result; also drive the clearing sweep writes
  always_comb begin
    playing_nxt = playing_r;
    fc_nxt      = fc_r;
    cur_we      = 1'b0;
    cur_waddr   = in_addr;
    cur_wdata   = in_cell_value;
    push        = 1'b0;
    push_res    = '{advanced: 1'b0, is_playing: playing_r, cell_alive: 1'b0};
    if (cmd.accept) begin
      case (func)
        tlag_pkg::FUNC_WRITE: begin
          cur_we = on_grid && !playing_r;
          push   = 1'b1;
        end
        tlag_pkg::FUNC_READ: begin
          push = 1'b0;
        end
        tlag_pkg::FUNC_CLEAR: begin
          playing_nxt         = 1'b0;
          push                = 1'b1;
          push_res.is_playing = 1'b0;
        end
        tlag_pkg::FUNC_START: begin
          playing_nxt         = 1'b1;
          push                = 1'b1;
          push_res.is_playing = 1'b1;
        end
        tlag_pkg::FUNC_TICK: begin
          fc_nxt            = frame_hit ? 8'd0 : fc_inc;
          push              = 1'b1;
          push_res.advanced = gen_due;
        end
        default: push = 1'b1;
      endcase
    end
    if (cmd.read_done) begin
      push                = 1'b1;
      push_res.cell_alive = rd_inside_r && cur_rdata;
    end
    if (cmd.clear_run) begin
      cur_we    = 1'b1;
      cur_waddr = clr_cnt_r;
      cur_wdata = 1'b0;
    end
  end

  // Mode, frame counter, speed, buffer select and clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= 1'b0;
      fc_r      <= 8'd0;
      fpg_r     <= tlag_pkg::FPG_RESET;
      buf_sel_r <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      playing_r <= playing_nxt;
      fc_r      <= fc_nxt;
      if (cfg_valid) begin
        fpg_r <= cfg_data;
      end
      if (cmd.gen_finish) begin
        buf_sel_r <= ~buf_sel_r;
      end
      if (cmd.clear_run) begin
        clr_cnt_r <= clear_last ? '0 : clr_cnt_r + AW'(1);
      end else begin
        clr_cnt_r <= '0;
      end
    end
    rd_inside_r <= on_grid;
  end

  // Advance the generation read counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_phase_r <= '0;
      rd_col_r   <= '0;
      d_valid_r  <= 1'b0;
    end else begin
      d_valid_r <= cmd.gen_issue;
      if (cmd.gen_issue) begin
        if (col_last) begin
          rd_col_r   <= '0;
          rd_phase_r <= phase_last ? '0 : rd_phase_r + PW'(1);
        end else begin
          rd_col_r <= rd_col_r + CW'(1);
        end
      end
    end
    d_phase_r <= rd_phase_r;
    d_col_r   <= rd_col_r;
  end

  // Rotate the three window rows, shift the incoming row, hand rows on at row end
  always_ff @(posedge clk) begin
    if (d_valid_r) begin
      row_d_r <= d_shift;
      if (d_col_r == CW'(GRID_COLS - 1)) begin
        row_a_r <= rot(row_b_r);
        row_b_r <= rot(row_c_r);
        row_c_r <= d_shift;
      end else begin
        row_a_r <= rot(row_a_r);
        row_b_r <= rot(row_b_r);
        row_c_r <= rot(row_c_r);
      end
    end
  end

  // Two grid buffers: current one edited and read, the other takes the new generation
  tlag_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (buf_sel_r ? gen_we : cur_we),
    .waddr (buf_sel_r ? gen_waddr : cur_waddr),
    .wdata (buf_sel_r ? next_alive : cur_wdata),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  tlag_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (buf_sel_r ? cur_we : gen_we),
    .waddr (buf_sel_r ? cur_waddr : gen_waddr),
    .wdata (buf_sel_r ? cur_wdata : next_alive),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  // Output register with a skid slot behind it
  assign pop = head_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        head_r   <= skid_r;
        skid_v_r <= push;
        if (push) begin
          skid_r <= push_res;
        end
      end else begin
        head_v_r <= push;
        head_r   <= push_res;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_v_r <= 1'b1;
        head_r   <= push_res;
      end else begin
        skid_v_r <= 1'b1;
        skid_r   <= push_res;
      end
    end
  end

  assign out_tvalid     = head_v_r;
  assign out_cell_alive = head_r.cell_alive;
  assign out_is_playing = head_r.is_playing;
  assign out_advanced   = head_r.advanced;

  assign status.func       = func;
  assign status.gen_due    = gen_due;
  assign status.clear_last = clear_last;
  assign status.issue_last = col_last && phase_last;
  assign status.skid_full  = skid_v_r;

endmodule

### rtl/toroidal_life_automaton_grid.sv
// Toroidal B3/S23 life grid of GRID_COLS x GRID_ROWS one-bit cells, held in two
// single-bit grid memories used in turn. Every input word gives exactly one result
// word. A cell read answers through the registered memory read. After a clear word
// the block sweeps the grid, one cell a cycle, before the next word is taken; the
// same pass runs after reset, while configuration writes are still taken. A tick
// that brings a generation streams the grid through the single read port of the
// grid memory, one cell a cycle, into four row registers, three of which form the
// 3x3 window while the fourth loads the row after next. Results queue in an output
// register with one skid slot, so a word is taken while a result waits.
module toroidal_life_automaton_grid #(
  parameter int GRID_COLS = 128,
  parameter int GRID_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // col[6:0], row[12:7], cell_value[13], zero[15:14]
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // cell_alive[0], is_playing[1], advanced[2], zero[7:3]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // frames_per_generation
);

  tlag_pkg::ctrl_cmd_t  cmd;
  tlag_pkg::dp_status_t status;
  logic                 cell_alive, is_playing, advanced;

  assign cfg_ready = 1'b1;

  tlag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tlag_dp #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_tuser),
    .in_col         (in_tdata[6:0]),
    .in_row         (in_tdata[12:7]),
    .in_cell_value  (in_tdata[13]),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_cell_alive (cell_alive),
    .out_is_playing (is_playing),
    .out_advanced   (advanced)
  );

  assign out_tdata = {5'd0, advanced, is_playing, cell_alive};

endmodule

### tb/life_grid_checker.sv
module life_grid_checker
  import tlag_pkg::*;
#(
  parameter int GRID_COLS = 128,
  parameter int GRID_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // col[6:0], row[12:7], cell_value[13], zero[15:14]
  input  logic [2:0]  in_tuser,   // func[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // cell_alive[0], is_playing[1], advanced[2], zero[7:3]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,   // frames_per_generation
  output int          pending,
  output int          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CELL_COUNT = GRID_COLS * GRID_ROWS;
  localparam int         BORN_AT    = 3;
  localparam int         KEEP_AT    = 2;
  localparam logic [7:0] FRAME_TOP  = 8'hFF;
  localparam logic [7:0] SPEED_INIT = 8'd1;

  // Result word, lowest bit last
  typedef struct packed {
    logic advanced;
    logic is_playing;
    logic cell_alive;
  } life_result_t;

  bit           cells [CELL_COUNT];
  bit           playing;
  logic [7:0]   frame_count;
  logic [7:0]   speed;
  life_result_t results_due [$];
  life_result_t want;
  life_result_t got;
  int           err_count = 0;

  assign mismatches = err_count;

  function automatic int alive_at(int c, int r);
    return cells[r * GRID_COLS + c];
  endfunction

  // Move the whole torus on by one B3/S23 generation
  function automatic void step_generation();
    bit nxt [CELL_COUNT];
    int up, dn, lf, rt, n;
    for (int r = 0; r < GRID_ROWS; r++) begin
      up = (r + GRID_ROWS - 1) % GRID_ROWS;
      dn = (r + 1) % GRID_ROWS;
      for (int c = 0; c < GRID_COLS; c++) begin
        lf = (c + GRID_COLS - 1) % GRID_COLS;
        rt = (c + 1) % GRID_COLS;
        n = alive_at(lf, up) + alive_at(c, up) + alive_at(rt, up)
          + alive_at(lf, r) + alive_at(rt, r)
          + alive_at(lf, dn) + alive_at(c, dn) + alive_at(rt, dn);
        if (cells[r * GRID_COLS + c])
          nxt[r * GRID_COLS + c] = (n == KEEP_AT) || (n == BORN_AT);
        else
          nxt[r * GRID_COLS + c] = (n == BORN_AT);
      end
    end
    cells = nxt;
  endfunction

  // Apply one input word to the grid and work out its result word
  function automatic life_result_t apply_word(logic [2:0] op, int col, int row, bit val);
    life_result_t res;
    bit           on_grid;
    res = '0;
    on_grid = (col < GRID_COLS) && (row < GRID_ROWS);
    case (op)
      FUNC_WRITE: if (on_grid && !playing) cells[row * GRID_COLS + col] = val;
      FUNC_READ:  if (on_grid) res.cell_alive = cells[row * GRID_COLS + col];
      FUNC_CLEAR: begin
        cells = '{default: 1'b0};
        playing = 1'b0;
      end
      FUNC_START: playing = 1'b1;
      FUNC_TICK: begin
        // saturate the frame counter, then wrap it at the configured speed
        if (frame_count != FRAME_TOP) frame_count++;
        if (frame_count >= speed) begin
          frame_count = '0;
          if (playing) begin
            step_generation();
            res.advanced = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.is_playing = playing;
    return res;
  endfunction

  task automatic check_field(string field, logic want_bit, logic got_bit);
    if (got_bit !== want_bit) begin
      err_count++;
      $error("%s: expected %0d, got %0d", field, want_bit, got_bit);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cells = '{default: 1'b0};
      playing = 1'b0;
      frame_count = '0;
      speed = SPEED_INIT;
      results_due.delete();
    end else begin
      // take a new speed setting
      if (cfg_valid && cfg_ready) speed = cfg_data;
      // compare a result word with the oldest expectation
      if (out_tvalid && out_tready) begin
        got = out_tdata[2:0];
        if (results_due.size() == 0) begin
          err_count++;
          $error("result word %h with nothing expected", out_tdata);
        end else begin
          want = results_due.pop_front();
          check_field("cell_alive", want.cell_alive, got.cell_alive);
          check_field("is_playing", want.is_playing, got.is_playing);
          check_field("advanced", want.advanced, got.advanced);
        end
      end
      // predict the result of an accepted word
      if (in_tvalid && in_tready)
        results_due.push_back(apply_word(in_tuser, int'(in_tdata[6:0]), int'(in_tdata[12:7]),
                                         in_tdata[13]));
    end
    pending <= results_due.size();
  end

endmodule

### tb/testbench.sv
module testbench;
  import tlag_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         COLS         = 128;
  localparam int         ROWS         = 64;
  localparam int         GEN_CYCLES   = (ROWS + 3) * COLS + 2;
  localparam int         CLEAR_CYCLES = COLS * ROWS;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         FLOOD_TICKS  = 6;
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam logic [7:0] SPEED_TOP     = 8'd255;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;
  int          results_pending;
  int          error_count;

  int          burst_left   = 0;
  int          words_sent   = 0;
  int          hot_col      = 0;
  int          hot_row      = 0;
  logic [7:0]  cur_speed    = 8'd1;
  longint      budget       = 40000;
  longint      cycle_count  = 0;
  int          holds_asked  = 0;
  int          holds_served = 0;
  int          hold_left    = 0;
  logic [9:0]  rx_phase     = '0;

  always #6 clk = ~clk;

  toroidal_life_automaton_grid #(
    .GRID_COLS (COLS),
    .GRID_ROWS (ROWS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  life_grid_checker #(
    .GRID_COLS (COLS),
    .GRID_ROWS (ROWS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pending    (results_pending),
    .mismatches (error_count)
  );

  // Stop a hung run well beyond the slowest expected progress
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3 * budget) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Result side: long hold-offs on request, otherwise a rotating stall pattern
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      case (rx_phase[9:8])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_tready <= (rx_phase[1:0] == 2'd0);
        default: out_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Offer one word and hold it until taken; idle between bursts
  task automatic send_word(logic [2:0] op, int col, int row, bit val);
    if (op == FUNC_TICK)
      budget += (cur_speed > 8'd1) ? GEN_CYCLES / cur_speed : GEN_CYCLES;
    else if (op == FUNC_CLEAR)
      budget += CLEAR_CYCLES;
    budget += 64;
    words_sent++;
    in_tuser <= op;
    in_tdata <= {2'b00, val, 6'(row), 7'(col)};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  // Hold the input until every expected result word has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic write_speed(logic [7:0] value);
    wait_drained();
    budget += GEN_CYCLES;
    cur_speed = value;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Write a cell relative to the current window, wrapping round the torus
  task automatic put_cell(int dc, int dr, bit v);
    send_word(FUNC_WRITE, (hot_col + dc) % COLS, (hot_row + dr) % ROWS, v);
  endtask

  // Read a cell in or just around the current window
  task automatic read_near();
    send_word(FUNC_READ, (hot_col + COLS - 1 + $urandom_range(0, 5)) % COLS,
              (hot_row + ROWS - 1 + $urandom_range(0, 5)) % ROWS, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_noise();
    send_word(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), $urandom_range(0, COLS - 1),
              $urandom_range(0, ROWS - 1), 1'($urandom_range(0, 1)));
  endtask

  // Window origin: mostly on or next to an edge so that wrapping is exercised
  function automatic int pick_origin(int span);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return span - 3;
      2:       return span - 1;
      default: return $urandom_range(0, span - 1);
    endcase
  endfunction

  task automatic place_blinker();
    put_cell(0, 1, 1'b1);
    put_cell(1, 1, 1'b1);
    put_cell(2, 1, 1'b1);
  endtask

  // Stall the result side for a long stretch while words keep coming
  task automatic press_output();
    holds_asked <= holds_asked + 1;
    budget += HOLD_CYCLES;
    burst_left = 16;
    repeat (8) read_near();
  endtask

  // Clear, draw a small pattern, play a few ticks and probe around it
  task automatic play_episode();
    int gl_c [5] = '{1, 2, 0, 1, 2};
    int gl_r [5] = '{0, 1, 2, 2, 2};
    send_word(FUNC_CLEAR, $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
              1'($urandom_range(0, 1)));
    hot_col = pick_origin(COLS);
    hot_row = pick_origin(ROWS);
    case ($urandom_range(0, 2))
      0: for (int k = 0; k < 5; k++) put_cell(gl_c[k], gl_r[k], 1'b1);
      1: place_blinker();
      default: repeat (6)
        put_cell($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 4) < 2);
    endcase
    if ($urandom_range(0, 3) == 0) send_noise();
    read_near();
    if ($urandom_range(0, 3) == 0) wait_drained();
    send_word(FUNC_START, $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
              1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) send_word(FUNC_START, 0, 0, 1'b0);
    repeat ($urandom_range(1, 4)) begin
      send_word(FUNC_TICK, $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
                1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 2)) read_near();
      // a write while playing must be dropped
      if ($urandom_range(0, 4) == 0) begin
        put_cell($urandom_range(0, 3), $urandom_range(0, 3), 1'b1);
        read_near();
      end
      if ($urandom_range(0, 6) == 0) send_noise();
    end
  endtask

  initial begin
    int         stop_at;
    logic [7:0] speeds [5];

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Horizontal blinker straddling the left and right edges of the top row
    send_word(FUNC_WRITE, COLS - 1, 0, 1'b1);
    send_word(FUNC_WRITE, 0, 0, 1'b1);
    send_word(FUNC_WRITE, 1, 0, 1'b1);
    // Bottom row: set a cell, then kill it
    send_word(FUNC_WRITE, 64, ROWS - 1, 1'b1);
    send_word(FUNC_WRITE, 64, ROWS - 1, 1'b0);
    send_word(FUNC_READ, COLS - 1, 0, 1'b0);
    send_word(FUNC_READ, 64, ROWS - 1, 1'b1);
    send_word(FUNC_READ, 0, ROWS - 1, 1'b0);
    // Spare codes with every field bit set
    for (int op = FUNC_SPARE_LO; op <= FUNC_SPARE_HI; op++)
      send_word(3'(op), COLS - 1, ROWS - 1, 1'b1);
    // Tick in edit mode: counter only
    send_word(FUNC_TICK, 0, 0, 1'b0);
    send_word(FUNC_START, 0, 0, 1'b0);
    send_word(FUNC_START, COLS - 1, ROWS - 1, 1'b1);
    // Write while playing is dropped
    send_word(FUNC_WRITE, 5, 5, 1'b1);
    send_word(FUNC_READ, 5, 5, 1'b0);
    // Blinker turns vertical across the top and bottom rows, then back
    send_word(FUNC_TICK, 0, 0, 1'b0);
    send_word(FUNC_READ, 0, ROWS - 1, 1'b0);
    send_word(FUNC_READ, 0, 1, 1'b0);
    send_word(FUNC_READ, COLS - 1, 0, 1'b0);
    send_word(FUNC_TICK, 0, 0, 1'b0);
    send_word(FUNC_READ, 1, 0, 1'b0);
    send_word(FUNC_CLEAR, 0, 0, 1'b0);
    send_word(FUNC_READ, 0, 0, 1'b0);

    // Random phases over several speeds, extremes among them
    speeds = '{8'd0, 8'd2, SPEED_TOP, 8'd1, 8'($urandom_range(3, 9))};
    for (int p = 0; p < 5; p++) begin
      write_speed(speeds[p]);
      if (p == 0 || p == 3) press_output();
      if (speeds[p] == SPEED_TOP) begin
        // a few ticks at the slowest speed: the counter climbs, no generation
        send_word(FUNC_CLEAR, 0, 0, 1'b0);
        hot_col = pick_origin(COLS);
        hot_row = pick_origin(ROWS);
        place_blinker();
        send_word(FUNC_START, 0, 0, 1'b0);
        repeat (FLOOD_TICKS) send_word(FUNC_TICK, 0, 0, 1'b0);
        repeat (2) read_near();
      end else begin
        stop_at = words_sent + 8;
        while (words_sent < stop_at) play_episode();
      end
    end

    // Drain and let the block settle
    wait_drained();
    repeat (30) @(posedge clk);
    if (error_count == 0 && results_pending == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

### filelist.f
rtl/tlag_pkg.sv
rtl/tlag_ram.sv
rtl/tlag_ctrl.sv
rtl/tlag_dp.sv
rtl/toroidal_life_automaton_grid.sv
tb/life_grid_checker.sv
tb/testbench.sv
